### hdl/single_bin_dft_magnitude_macros.svh
// assertion macros for the single bin dft magnitude block
`ifndef SINGLE_BIN_DFT_MAGNITUDE_MACROS_SVH
`define SINGLE_BIN_DFT_MAGNITUDE_MACROS_SVH

`ifndef ASSERT_OFF
`define SBDM_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SBDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SBDM_ASSERT_ALWAYS(label, expr, msg)
`define SBDM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/sbdm_pkg.sv
package sbdm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TW_W = 18;
	localparam int SUM_W = 32;
	localparam int MAG_W = 28;
	localparam int RAD_W = 2 * SUM_W;
	localparam int ROOT_W = SUM_W;

	localparam int MAX_BLOCK = 4096;
	localparam int CNT_W = $clog2(MAX_BLOCK);

	localparam int ROOT_STEPS = ROOT_W;
	localparam int STEP_W = $clog2(ROOT_STEPS);

	localparam logic signed [TW_W-1:0] PH_ONE = 18'sh1FFFF;
	localparam logic signed [TW_W-1:0] PH_ZERO = 18'sh00000;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLE_COS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLE_SIN_NEG = 1'b1;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic sqr;
		logic add;
		logic step;
		logic emit;
	} sbdm_cmd_t;

endpackage

### hdl/sbdm_isqrt.sv
module sbdm_isqrt (
	input  logic                            clk,
	input  logic                            start,
	input  logic                            step,
	input  logic [sbdm_pkg::RAD_W-1:0]      radicand,
	output logic [sbdm_pkg::ROOT_W-1:0]     root
);

	localparam int REM_W = sbdm_pkg::ROOT_W + 2;
	localparam int SH_W = REM_W + 2;

	logic [sbdm_pkg::RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [sbdm_pkg::ROOT_W-1:0] root_q;
	logic [SH_W-1:0]             rem_sh;
	logic [SH_W-1:0]             trial;
	logic [SH_W-1:0]             rem_n;
	logic                        ge;

	// one result bit per step, two radicand bits in
	always_comb begin
		rem_sh = {rem_q, rad_q[sbdm_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge = (rem_sh >= trial);
		rem_n = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q <= {rad_q[sbdm_pkg::RAD_W-3:0], 2'b00};
			rem_q <= rem_n[REM_W-1:0];
			root_q <= {root_q[sbdm_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;

endmodule

### hdl/sbdm_ctrl.sv
module sbdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output sbdm_pkg::sbdm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_ROOT = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]                  state_q;
	logic [2:0]                  state_n;
	logic [sbdm_pkg::CNT_W-1:0]  cnt_q;
	logic [sbdm_pkg::STEP_W-1:0] step_q;
	logic                        last_q;
	logic                        out_valid_q;
	logic                        xfer_in;
	logic                        last_eff;
	logic                        step_done;

	assign xfer_in = in_valid && (state_q == ST_IDLE);
	// overlong block closes itself
	assign last_eff = last || (cnt_q == sbdm_pkg::CNT_W'(sbdm_pkg::MAX_BLOCK - 1));
	assign step_done = (step_q == sbdm_pkg::STEP_W'(sbdm_pkg::ROOT_STEPS - 1));

	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_n = last_q ? ST_SQR : ST_IDLE;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_n = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_n = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.step = 1'b1;
				if (step_done) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold the root until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (xfer_in) begin
				cnt_q <= last_eff ? '0 : cnt_q + 1'b1;
				last_q <= last_eff;
			end
			if (cmd.add) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hdl/sbdm_dp.sv
module sbdm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sbdm_pkg::sbdm_cmd_t                  cmd,
	input  logic signed [sbdm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 cfg_wr_en,
	input  logic [sbdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbdm_pkg::TW_W-1:0]            cfg_data,
	output logic [sbdm_pkg::MAG_W-1:0]           magnitude,
	output logic                                 overflow
);

	localparam int PS_W = sbdm_pkg::SAMPLE_W + sbdm_pkg::TW_W;
	localparam int PP_W = 2 * sbdm_pkg::TW_W;
	localparam int Q = 17;
	localparam int RS_W = PS_W - Q;
	localparam int RP_W = PP_W + 1 - Q;

	logic signed [sbdm_pkg::TW_W-1:0]     tw_cos_q;
	logic signed [sbdm_pkg::TW_W-1:0]     tw_sin_q;
	logic signed [sbdm_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [sbdm_pkg::TW_W-1:0]     ph_re_q;
	logic signed [sbdm_pkg::TW_W-1:0]     ph_im_q;
	logic signed [sbdm_pkg::SUM_W-1:0]    sum_re_q;
	logic signed [sbdm_pkg::SUM_W-1:0]    sum_im_q;
	logic                                 sat_q;
	logic                                 blk_ovf_q;

	logic signed [PS_W-1:0] p_sr_q;
	logic signed [PS_W-1:0] p_si_q;
	logic signed [PP_W-1:0] p_rc_q;
	logic signed [PP_W-1:0] p_is_q;
	logic signed [PP_W-1:0] p_rs_q;
	logic signed [PP_W-1:0] p_ic_q;

	logic [sbdm_pkg::RAD_W-1:0]  sq_re_q;
	logic [sbdm_pkg::RAD_W-1:0]  sq_im_q;
	logic [sbdm_pkg::MAG_W-1:0]  mag_q;
	logic                        ovf_q;

	logic [PS_W-1:0]            sr_full;
	logic [PS_W-1:0]            si_full;
	logic [RS_W-1:0]            sr_r;
	logic [RS_W-1:0]            si_r;
	logic [sbdm_pkg::SUM_W:0]   sre_n;
	logic [sbdm_pkg::SUM_W:0]   sim_n;
	logic                       sre_sat;
	logic                       sim_sat;
	logic [sbdm_pkg::SUM_W-1:0] sre_c;
	logic [sbdm_pkg::SUM_W-1:0] sim_c;
	logic [PP_W:0]              dre;
	logic [PP_W:0]              dim;
	logic [RP_W-1:0]            re_r;
	logic [RP_W-1:0]            im_r;
	logic [sbdm_pkg::TW_W-1:0]  re_c;
	logic [sbdm_pkg::TW_W-1:0]  im_c;
	logic [sbdm_pkg::SUM_W-1:0] abs_re;
	logic [sbdm_pkg::SUM_W-1:0] abs_im;
	logic [sbdm_pkg::ROOT_W-1:0] root;
	logic [sbdm_pkg::RAD_W-1:0]  rad;
	logic                        mag_big;

	// round half up then drop the fraction
	always_comb begin
		sr_full = p_sr_q + PS_W'(1 << (Q - 1));
		si_full = p_si_q + PS_W'(1 << (Q - 1));
		sr_r = sr_full[PS_W-1:Q];
		si_r = si_full[PS_W-1:Q];
		sre_n = {sum_re_q[sbdm_pkg::SUM_W-1], sum_re_q}
			+ {{(sbdm_pkg::SUM_W + 1 - RS_W){sr_r[RS_W-1]}}, sr_r};
		sim_n = {sum_im_q[sbdm_pkg::SUM_W-1], sum_im_q}
			+ {{(sbdm_pkg::SUM_W + 1 - RS_W){si_r[RS_W-1]}}, si_r};
		sre_sat = sre_n[sbdm_pkg::SUM_W] ^ sre_n[sbdm_pkg::SUM_W-1];
		sim_sat = sim_n[sbdm_pkg::SUM_W] ^ sim_n[sbdm_pkg::SUM_W-1];
		sre_c = sre_sat ? {sre_n[sbdm_pkg::SUM_W], {(sbdm_pkg::SUM_W-1){~sre_n[sbdm_pkg::SUM_W]}}}
			: sre_n[sbdm_pkg::SUM_W-1:0];
		sim_c = sim_sat ? {sim_n[sbdm_pkg::SUM_W], {(sbdm_pkg::SUM_W-1){~sim_n[sbdm_pkg::SUM_W]}}}
			: sim_n[sbdm_pkg::SUM_W-1:0];

		dre = {p_rc_q[PP_W-1], p_rc_q} - {p_is_q[PP_W-1], p_is_q} + (PP_W+1)'(1 << (Q - 1));
		dim = {p_rs_q[PP_W-1], p_rs_q} + {p_ic_q[PP_W-1], p_ic_q} + (PP_W+1)'(1 << (Q - 1));
		re_r = dre[PP_W:Q];
		im_r = dim[PP_W:Q];
		if (re_r[RP_W-1:sbdm_pkg::TW_W-1] == '0 || re_r[RP_W-1:sbdm_pkg::TW_W-1] == '1) begin
			re_c = re_r[sbdm_pkg::TW_W-1:0];
		end else begin
			re_c = {re_r[RP_W-1], {(sbdm_pkg::TW_W-1){~re_r[RP_W-1]}}};
		end
		if (im_r[RP_W-1:sbdm_pkg::TW_W-1] == '0 || im_r[RP_W-1:sbdm_pkg::TW_W-1] == '1) begin
			im_c = im_r[sbdm_pkg::TW_W-1:0];
		end else begin
			im_c = {im_r[RP_W-1], {(sbdm_pkg::TW_W-1){~im_r[RP_W-1]}}};
		end

		abs_re = sum_re_q[sbdm_pkg::SUM_W-1] ? sbdm_pkg::SUM_W'(-sum_re_q) : sum_re_q;
		abs_im = sum_im_q[sbdm_pkg::SUM_W-1] ? sbdm_pkg::SUM_W'(-sum_im_q) : sum_im_q;
		rad = sq_re_q + sq_im_q;
		mag_big = |root[sbdm_pkg::ROOT_W-1:sbdm_pkg::MAG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_cos_q <= sbdm_pkg::PH_ONE;
			tw_sin_q <= sbdm_pkg::PH_ZERO;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sbdm_pkg::CFG_TWIDDLE_COS: tw_cos_q <= cfg_data;
				sbdm_pkg::CFG_TWIDDLE_SIN_NEG: tw_sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_re_q <= sbdm_pkg::PH_ONE;
			ph_im_q <= sbdm_pkg::PH_ZERO;
			sum_re_q <= '0;
			sum_im_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.acc) begin
			ph_re_q <= re_c;
			ph_im_q <= im_c;
			sum_re_q <= sre_c;
			sum_im_q <= sim_c;
			sat_q <= sat_q | sre_sat | sim_sat;
		end else if (cmd.sqr) begin
			// block restart once the sums are taken
			ph_re_q <= sbdm_pkg::PH_ONE;
			ph_im_q <= sbdm_pkg::PH_ZERO;
			sum_re_q <= '0;
			sum_im_q <= '0;
			sat_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.mul) begin
			p_sr_q <= sample_q * ph_re_q;
			p_si_q <= sample_q * ph_im_q;
			p_rc_q <= ph_re_q * tw_cos_q;
			p_is_q <= ph_im_q * tw_sin_q;
			p_rs_q <= ph_re_q * tw_sin_q;
			p_ic_q <= ph_im_q * tw_cos_q;
		end
		if (cmd.sqr) begin
			sq_re_q <= abs_re * abs_re;
			sq_im_q <= abs_im * abs_im;
			blk_ovf_q <= sat_q;
		end
		if (cmd.emit) begin
			mag_q <= mag_big ? sbdm_pkg::MAG_MAX : root[sbdm_pkg::MAG_W-1:0];
			ovf_q <= blk_ovf_q | mag_big;
		end
	end

	sbdm_isqrt u_isqrt (
		.clk      (clk),
		.start    (cmd.add),
		.step     (cmd.step),
		.radicand (rad),
		.root     (root)
	);

	assign magnitude = mag_q;
	assign overflow = ovf_q;

endmodule

### hdl/single_bin_dft_magnitude.sv
// non-final sample: in_ready low for the multiply and accumulate, next sample waits for both
// final sample: after multiply and accumulate, the sums are squared and added, then the
// 32-step bit-serial square root unit runs; the root waits for a free output register
// a pending result waits in the output register while the next block streams in
// reset: asynchronous, clears sums, phasor to one, saturation flag, sample count,
// pending result, twiddles back to cos one and sin zero
`include "single_bin_dft_magnitude_macros.svh"

module single_bin_dft_magnitude (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sbdm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sbdm_pkg::MAG_W-1:0]           magnitude,
	output logic                                 overflow,
	input  logic                                 cfg_wr_en,
	input  logic [sbdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbdm_pkg::TW_W-1:0]            cfg_data
);

	sbdm_pkg::sbdm_cmd_t cmd;

	sbdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sbdm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (sample),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.magnitude (magnitude),
		.overflow  (overflow)
	);

	`SBDM_ASSERT_ALWAYS(a_emit_no_overwrite, !cmd.emit || !out_valid || out_ready, "result overwritten")
	`SBDM_ASSERT_NEXT(a_xfer_then_mul, in_valid && in_ready, cmd.mul && !in_ready, "no multiply after transfer")
	`SBDM_ASSERT_NEXT(a_mul_then_acc, cmd.mul, cmd.acc, "no accumulate after multiply")

endmodule
